// File: sv/twlrs_pkg.sv
// shared types and constants for the three-way largest-remainder split
package twlrs_pkg;

  localparam int NUM_CLASSES = 3;

  typedef logic [1:0] cls_t;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_SHORT = 2'd2;

  // outcome of one top-up selection
  typedef struct packed {
    logic found;
    cls_t idx;
  } pick_t;

endpackage

// File: sv/twlrs_div.sv
// restoring divider, one quotient bit per cycle
module twlrs_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, divisor};
    fits    = (trial >= {1'b0, divisor});
    quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
    rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: sv/twlrs_pick.sv
// picks the unused class with the largest remainder, lowest index on ties
module twlrs_pick #(
  parameter int REM_W = 16
) (
  input  logic [REM_W-1:0]                  rem [twlrs_pkg::NUM_CLASSES],
  input  logic [twlrs_pkg::NUM_CLASSES-1:0] used,
  output twlrs_pkg::pick_t                  pick
);

  always_comb begin
    pick.found = 1'b0;
    pick.idx   = '0;
    for (int k = 0; k < twlrs_pkg::NUM_CLASSES; k++) begin
      if (!used[k] && (!pick.found || rem[k] > rem[pick.idx])) begin
        pick.found = 1'b1;
        pick.idx   = twlrs_pkg::cls_t'(k);
      end
    end
  end

endmodule

// File: sv/three_way_largest_remainder_split.sv
// top level of the three-way largest-remainder split
//
// usage:
//   the input channel (in_valid/in_ready) carries one item: slots wanted, pool
//   total and the three class counts. the result channel (out_valid/out_ready)
//   returns the three shares and a status code for that item.
//   one item is in flight at a time; in_ready is high only while the block
//   is empty.
// sequence:
//   each class passes through a multiply state (S_MUL), a divider load state
//   (S_LOAD) and a wait in S_DIV while the one shared divider works through
//   the 2*W dividend bits (W = min(COUNT_BITS,16)); the quotient and remainder
//   are collected as S_DIV ends. the top-up state S_TOP then adds at most one
//   slot per class. the next item can be taken in the cycle after the result
//   leaves. an empty pool skips the divisions: out_valid rises in the cycle after accept.
// reset:
//   rst_n is synchronous and active low; it empties the block and drops
//   out_valid. there is no stored state between items.
// stalls:
//   the result stays on the out_ ports until out_ready takes it; no new
//   item is taken before then.
module three_way_largest_remainder_split #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_slots_wanted,
  input  logic [15:0] in_pool_total,
  input  logic [15:0] in_avail_class0,
  input  logic [15:0] in_avail_class1,
  input  logic [15:0] in_avail_class2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_share_class0,
  output logic [15:0] out_share_class1,
  output logic [15:0] out_share_class2,
  output logic [1:0]  out_status
);

  // effective count width: inputs are 16 bits, bits above COUNT_BITS ignored
  localparam int IW    = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam int PW    = 2 * IW;
  localparam int SUM_W = PW + 2;
  localparam int NC    = twlrs_pkg::NUM_CLASSES;
  localparam logic [PW-1:0] SHARE_LIM = {{(PW - IW){1'b0}}, {IW{1'b1}}};

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_TOP  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                state_r, state_nxt;
  twlrs_pkg::cls_t           k_r;
  logic [NC-1:0]             used_r;
  twlrs_pkg::status_t        status_r;

  logic [IW-1:0]             slots_r;
  logic [IW-1:0]             total_r;
  logic [IW-1:0]             avail_r [NC];
  logic [PW-1:0]             prod_r;
  logic [PW-1:0]             share_r [NC];
  logic [IW-1:0]             rem_r   [NC];
  logic [SUM_W-1:0]          sum_r;

  logic                      in_acc;
  logic                      div_start;
  logic                      div_done;
  logic [PW-1:0]             div_quo;
  logic [IW-1:0]             div_rem;
  twlrs_pkg::pick_t          pick;
  logic                      short;
  logic [PW-1:0]             share_sat [NC];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign div_start = (state_r == S_LOAD);
  assign short     = (sum_r < SUM_W'(slots_r));

  // shared divider: product of count and slots over the pool total
  twlrs_div #(
    .DIVIDEND_W (PW),
    .DIVISOR_W  (IW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (prod_r),
    .divisor   (total_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // top-up choice among classes not yet topped up
  twlrs_pick #(
    .REM_W (IW)
  ) u_pick (
    .rem  (rem_r),
    .used (used_r),
    .pick (pick)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // empty pool: no division at all
          state_nxt = (in_pool_total[IW-1:0] == '0) ? S_OUT : S_MUL;
        end
      end
      S_MUL:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = (k_r == twlrs_pkg::cls_t'(NC - 1)) ? S_TOP : S_MUL;
        end
      end
      S_TOP: begin
        // one slot per cycle until the sum reaches the target or classes run out
        if (!(short && pick.found)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          slots_r    <= in_slots_wanted[IW-1:0];
          total_r    <= in_pool_total[IW-1:0];
          avail_r[0] <= in_avail_class0[IW-1:0];
          avail_r[1] <= in_avail_class1[IW-1:0];
          avail_r[2] <= in_avail_class2[IW-1:0];
          k_r        <= '0;
          used_r     <= '0;
          sum_r      <= '0;
          for (int k = 0; k < NC; k++) begin
            share_r[k] <= '0;
            rem_r[k]   <= '0;
          end
          if (in_pool_total[IW-1:0] == '0 && in_slots_wanted[IW-1:0] != '0) begin
            status_r <= twlrs_pkg::ST_EMPTY;
          end else begin
            status_r <= twlrs_pkg::ST_OK;
          end
        end
      end
      S_MUL: begin
        prod_r <= PW'(avail_r[k_r]) * PW'(slots_r);
      end
      S_LOAD: begin
      end
      S_DIV: begin
        if (div_done) begin
          share_r[k_r] <= div_quo;
          rem_r[k_r]   <= div_rem;
          sum_r        <= sum_r + SUM_W'(div_quo);
          k_r          <= k_r + twlrs_pkg::cls_t'(1);
        end
      end
      S_TOP: begin
        if (short && pick.found) begin
          share_r[pick.idx] <= share_r[pick.idx] + PW'(1);
          used_r[pick.idx]  <= 1'b1;
          sum_r             <= sum_r + SUM_W'(1);
        end else if (short) begin
          status_r <= twlrs_pkg::ST_SHORT;
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // shares clamp to the largest count value
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      share_sat[k] = (share_r[k] > SHARE_LIM) ? SHARE_LIM : share_r[k];
    end
  end

  assign out_share_class0 = 16'(share_sat[0]);
  assign out_share_class1 = 16'(share_sat[1]);
  assign out_share_class2 = 16'(share_sat[2]);
  assign out_status       = status_r;

  // the block never takes an item while holding a result
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside of division wait");

  // an empty-pool result carries all-zero shares
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == twlrs_pkg::ST_EMPTY) |->
      (out_share_class0 == '0 && out_share_class1 == '0 && out_share_class2 == '0))
    else $error("empty pool result with nonzero share");

  // each top-up cycle marks at most one more class as used
  a_topup_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TOP) |=> ($countones(used_r) <= $countones($past(used_r)) + 1))
    else $error("more than one class topped up in a cycle");

  // a shortfall is only flagged once every class has been topped up
  a_short_all_used: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == twlrs_pkg::ST_SHORT) |-> (used_r == {NC{1'b1}}))
    else $error("shortfall flagged with a class still unused");

endmodule
